### sv/c_identifier_scanner_top_assert.svh
// Assertion macros for the identifier scanner.
// Included by the top level; needs nothing else.
`ifndef C_IDENTIFIER_SCANNER_TOP_ASSERT_SVH
`define C_IDENTIFIER_SCANNER_TOP_ASSERT_SVH

// Checked on the rising edge, off while reset is asserted.
`define CIS_ASSERT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CIS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

### sv/cis_pkg.sv
// Shared types, codes and character classes for the identifier scanner.
// No dependencies.
package cis_pkg;

	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} in_t;

	typedef struct packed {
		logic [7:0] ident_char;
		logic       ident_last;
	} out_t;

	// One queue entry: the one or two results caused by one input byte.
	typedef struct packed {
		logic two;
		out_t r0;
		out_t r1;
	} pair_t;

	// Scanner status seen by the top level.
	typedef struct packed {
		logic [2:0] mode;
		logic       held_valid;
	} front_status_t;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_SLASH   = 3'd1;
	localparam logic [2:0] MODE_STR     = 3'd2;
	localparam logic [2:0] MODE_STR_ESC = 3'd3;
	localparam logic [2:0] MODE_CHR     = 3'd4;
	localparam logic [2:0] MODE_CHR_ESC = 3'd5;
	localparam logic [2:0] MODE_COMMENT = 3'd6;

	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_DQUOTE     = 8'h22;
	localparam logic [7:0] CH_SQUOTE     = 8'h27;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	function automatic logic is_start(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_start(c) || (c >= 8'h30 && c <= 8'h39);
	endfunction

endpackage

### sv/cis_front.sv
// Front end: lexer mode tracking and identifier hold register.
// Turns each accepted byte into zero, one or two results, pushed as one queue entry when there are any. Uses cis_pkg.
module cis_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  cis_pkg::in_t           item,
	output logic                   push_en,
	output cis_pkg::pair_t         push_data,
	output cis_pkg::front_status_t status
);

	logic [2:0] mode_q;
	logic [7:0] held_char_q;
	logic       held_valid_q;

	logic [2:0] mode_d;
	logic [7:0] held_char_d;
	logic       held_valid_d;
	logic [1:0] cnt;
	cis_pkg::out_t res0;
	cis_pkg::out_t res1;

	always_comb begin
		logic [7:0] c;
		c            = item.char_in;
		mode_d       = mode_q;
		held_char_d  = held_char_q;
		held_valid_d = held_valid_q;
		cnt          = 2'd0;
		res0         = '0;
		res1         = '0;

		unique case (mode_q)
			cis_pkg::MODE_STR: begin
				if (c == cis_pkg::CH_BACKSLASH) mode_d = cis_pkg::MODE_STR_ESC;
				else if (c == cis_pkg::CH_DQUOTE) mode_d = cis_pkg::MODE_NORMAL;
			end
			cis_pkg::MODE_STR_ESC: mode_d = cis_pkg::MODE_STR;
			cis_pkg::MODE_CHR: begin
				if (c == cis_pkg::CH_BACKSLASH) mode_d = cis_pkg::MODE_CHR_ESC;
				else if (c == cis_pkg::CH_SQUOTE) mode_d = cis_pkg::MODE_NORMAL;
			end
			cis_pkg::MODE_CHR_ESC: mode_d = cis_pkg::MODE_CHR;
			cis_pkg::MODE_COMMENT: mode_d = cis_pkg::MODE_COMMENT;
			default: begin
				if (mode_q == cis_pkg::MODE_SLASH && c == cis_pkg::CH_SLASH) begin
					mode_d = cis_pkg::MODE_COMMENT;
				end else begin
					mode_d = cis_pkg::MODE_NORMAL;
					if (held_valid_q) begin
						res0.ident_char = held_char_q;
						cnt             = 2'd1;
						if (cis_pkg::is_ident(c)) begin
							res0.ident_last = 1'b0;
							held_char_d     = c;
						end else begin
							res0.ident_last = 1'b1;
							held_valid_d    = 1'b0;
							held_char_d     = 8'h00;
						end
					end else if (cis_pkg::is_start(c)) begin
						held_char_d  = c;
						held_valid_d = 1'b1;
					end
					if (c == cis_pkg::CH_DQUOTE) mode_d = cis_pkg::MODE_STR;
					else if (c == cis_pkg::CH_SQUOTE) mode_d = cis_pkg::MODE_CHR;
					else if (c == cis_pkg::CH_SLASH) mode_d = cis_pkg::MODE_SLASH;
				end
			end
		endcase

		// line end flushes the held character and returns to reset state
		if (item.line_end) begin
			if (held_valid_d) begin
				if (cnt == 2'd0) begin
					res0 = '{ident_char: held_char_d, ident_last: 1'b1};
				end else begin
					res1 = '{ident_char: held_char_d, ident_last: 1'b1};
				end
				cnt = cnt + 2'd1;
			end
			mode_d       = cis_pkg::MODE_NORMAL;
			held_char_d  = 8'h00;
			held_valid_d = 1'b0;
		end
	end

	assign push_en        = accept && (cnt != 2'd0);
	assign push_data.two  = cnt[1];
	assign push_data.r0   = res0;
	assign push_data.r1   = res1;
	assign status.mode       = mode_q;
	assign status.held_valid = held_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= cis_pkg::MODE_NORMAL;
			held_char_q  <= 8'h00;
			held_valid_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_d;
			held_char_q  <= held_char_d;
			held_valid_q <= held_valid_d;
		end
	end

endmodule

### sv/cis_queue.sv
// Small entry queue between front end and result stage.
// Register array with wrap-around pointers. Uses cis_pkg.
module cis_queue #(
	parameter int DEPTH = cis_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  cis_pkg::pair_t               wr_data,
	input  logic                         rd_en,
	output cis_pkg::pair_t               rd_data,
	output logic                         full,
	output logic                         nonempty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cis_pkg::pair_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign count    = count_q;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd_en) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr_en && !rd_en) count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en) count_q <= count_q - CW'(1);
		end
	end

endmodule

### sv/cis_back.sv
// Result stage: holds one queue entry and hands out its results one per pop.
// Uses cis_pkg.
module cis_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_nonempty,
	input  cis_pkg::pair_t q_data,
	output logic           q_rd,
	input  logic           pop,
	output logic           empty,
	output cis_pkg::out_t  res
);

	cis_pkg::pair_t cur_q;
	logic           cur_v_q;
	logic           idx_q;

	logic pop_fire;
	logic last_of_entry;

	assign pop_fire      = pop && cur_v_q;
	assign last_of_entry = !cur_q.two || idx_q;
	assign q_rd          = q_nonempty && (!cur_v_q || (pop_fire && last_of_entry));
	assign empty         = !cur_v_q;
	assign res           = idx_q ? cur_q.r1 : cur_q.r0;

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_v_q <= 1'b1;
				idx_q   <= 1'b0;
			end else if (pop_fire) begin
				if (last_of_entry) begin
					cur_v_q <= 1'b0;
					idx_q   <= 1'b0;
				end else begin
					idx_q <= 1'b1;
				end
			end
		end
	end

endmodule

### sv/c_identifier_scanner_top.sv
// Top level of the C identifier scanner: front end, entry queue, result stage.
// Depends on cis_pkg, cis_front, cis_queue, cis_back and the assertion macro header.
`include "c_identifier_scanner_top_assert.svh"

// Scans one source line a byte per request and returns the characters of every C
// identifier found, with ident_last set on each identifier's final character.
// // comments, string literals and character literals (with backslash escapes) are
// skipped; a byte flagged line_end closes everything and flushes the pending
// identifier. The input side takes one byte every cycle while full is low: the
// front end updates its mode register as each byte is taken. A byte yields zero,
// one or two results; results of one byte are queued as one entry in a
// QUEUE_DEPTH-entry queue, and the result side hands out one result per cycle
// while pop is high and empty is low. A result is written into the queue and
// then loaded into the result stage register before it appears on the result
// ports. full rises when the queue holds QUEUE_DEPTH entries, so a byte rate
// of one per cycle holds while the results are popped about as fast as they are made.
module c_identifier_scanner_top #(
	parameter int QUEUE_DEPTH = cis_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  cis_pkg::in_t  byte_item,
	output logic          empty,
	input  logic          pop,
	output cis_pkg::out_t ident_item
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic                   accept;
	logic                   q_wr;
	cis_pkg::pair_t         q_wdata;
	logic                   q_rd;
	cis_pkg::pair_t         q_rdata;
	logic                   q_nonempty;
	logic [CW-1:0]          q_count;
	cis_pkg::front_status_t fstat;

	// a request is taken whenever the queue has room for one more entry
	assign accept = push && !full;

	cis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (byte_item),
		.push_en   (q_wr),
		.push_data (q_wdata),
		.status    (fstat)
	);

	cis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_wr),
		.wr_data  (q_wdata),
		.rd_en    (q_rd),
		.rd_data  (q_rdata),
		.full     (full),
		.nonempty (q_nonempty),
		.count    (q_count)
	);

	cis_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_rdata),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.res        (ident_item)
	);

	// line end always returns the front end to its reset state
	`CIS_ASSERT(a_line_end_clears, clk, arst_n, accept && byte_item.line_end |=> (fstat.mode == cis_pkg::MODE_NORMAL) && !fstat.held_valid, "scanner state not cleared after line end")
	// while the queue holds an entry, the result stage is never left empty
	`CIS_ASSERT(a_queue_drains, clk, arst_n, q_nonempty |=> !empty, "result stage idle while queue holds entries")
	// the queue never overfills; the count is only meaningful once reset has acted
	`CIS_ASSERT_ALWAYS(a_queue_bound, clk, !arst_n || (q_count <= CW'(QUEUE_DEPTH)), "queue count above depth")

endmodule
